>>> hw/rtl/srd_pkg.sv
package srd_pkg;

    typedef enum logic [1:0] {
        CMD_ARM     = 2'd0,
        CMD_BYTE    = 2'd1,
        CMD_TIMEOUT = 2'd2
    } srd_cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_CHECKSUM    = 3'd1,
        ST_PARITY      = 3'd2,
        ST_BAD_PARAM   = 3'd3,
        ST_NO_ANSWER   = 3'd4,
        ST_OVERFLOW    = 3'd5
    } srd_status_t;

    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_EXT = 8'h21;
    localparam logic [7:0] CH_PAR = 8'h3F;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

endpackage

>>> hw/rtl/serial_response_deframer_core.sv
// Receive-side deframer for a two-wire parameter read. An arm word
// (tuser cmd 0) loads the expected parameter code; byte words (cmd 1)
// are then framed: hunt for STX, check the header, pass value characters
// out one per result word, and close with a status word (tlast high)
// after the XOR check byte, on an error code, on overflow, or on a
// timeout word (cmd 2). The core takes one word per clock with no
// stalls of its own; a result appears on the master side the cycle
// after the word that caused it, and the slave side is held only while
// a result waits in the output register. The standard-mode code
// characters come out of a two-step constant-divide pipeline behind the
// arm register, done before the earliest header byte that needs them.
module serial_response_deframer_core
    import srd_pkg::*;
#(
    parameter int MAX_DATA = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] param_code, [23:16] sub_code, [31:24] rx_byte
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd, [2] extended
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] data_char, [10:8] status, [15:11] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (8'd48 + 8'(v)) : (8'd55 + 8'(v));
    endfunction

    // input fields
    srd_cmd_t    in_cmd;
    logic        in_ext;
    logic [15:0] in_code;
    logic [7:0]  in_sub;
    logic [7:0]  in_byte;
    logic        s_accept;

    assign in_cmd   = srd_cmd_t'(s_tuser[1:0]);
    assign in_ext   = s_tuser[2];
    assign in_code  = s_tdata[15:0];
    assign in_sub   = s_tdata[23:16];
    assign in_byte  = s_tdata[31:24];

    // frame state
    logic        busy_reg, busy_next;
    logic        synced_reg, synced_next;
    logic        ext_mode_reg, ext_mode_next;
    logic [7:0]  pos_reg, pos_next;
    logic        await_reg, await_next;
    logic [7:0]  xor_reg, xor_next;
    logic [47:0] exp_ext_reg, exp_ext_next;

    // standard code pipeline
    logic [15:0] code_reg;
    logic [6:0]  dv_reg;
    logic [12:0] q10_reg;
    logic [7:0]  c1_reg, c2_reg;
    logic [32:0] dv_prod;
    logic [31:0] q10_prod;
    logic [15:0] r10_full;
    logic [15:0] c1_full, c2_full;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_char_reg, m_char_next;
    logic [2:0]  m_status_reg, m_status_next;
    logic        m_last_reg, m_last_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_status_reg, m_char_reg};
    assign m_tlast  = m_last_reg;

    // code / 790 and code / 10 by reciprocal multiply
    assign dv_prod  = 33'(code_reg) * 33'd84948;
    assign q10_prod = 32'(code_reg) * 32'd52429;
    assign r10_full = code_reg - 16'(q10_reg) * 16'd10;
    assign c1_full  = 16'(q10_reg) - 16'(dv_reg) * 16'd79 + 16'd48;
    assign c2_full  = r10_full + 16'(dv_reg) * 16'd10 + 16'd48;

    always_ff @(posedge aclk) begin
        if (s_accept && in_cmd == CMD_ARM) begin
            code_reg <= in_code;
        end
        dv_reg  <= dv_prod[32:26];
        q10_reg <= q10_prod[31:19];
        c1_reg  <= c1_full[7:0];
        c2_reg  <= c2_full[7:0];
    end

    logic [7:0] hdr_len;
    logic [7:0] rel_pos;
    logic [2:0] ext_idx;
    logic [7:0] ext_char;

    assign hdr_len = ext_mode_reg ? 8'd8 : 8'd3;
    assign rel_pos = pos_reg - hdr_len;
    assign ext_idx = pos_reg[2:0] - 3'd2;

    always_comb begin
        case (ext_idx)
            3'd0:    ext_char = exp_ext_reg[7:0];
            3'd1:    ext_char = exp_ext_reg[15:8];
            3'd2:    ext_char = exp_ext_reg[23:16];
            3'd3:    ext_char = exp_ext_reg[31:24];
            3'd4:    ext_char = exp_ext_reg[39:32];
            3'd5:    ext_char = exp_ext_reg[47:40];
            default: ext_char = 8'd0;
        endcase
    end

    logic        do_finish;
    srd_status_t fin_status;
    logic        do_emit;
    logic        hdr_bad;

    always_comb begin
        busy_next     = busy_reg;
        synced_next   = synced_reg;
        ext_mode_next = ext_mode_reg;
        pos_next      = pos_reg;
        await_next    = await_reg;
        xor_next      = xor_reg;
        exp_ext_next  = exp_ext_reg;
        do_finish     = 1'b0;
        fin_status    = ST_OK;
        do_emit       = 1'b0;
        hdr_bad       = 1'b0;

        if (s_accept) begin
            case (in_cmd)
                CMD_ARM: begin
                    ext_mode_next = in_ext;
                    if (in_ext) begin
                        exp_ext_next = {hex_char(in_sub[3:0]), hex_char(in_sub[7:4]),
                                        hex_char(in_code[3:0]), hex_char(in_code[7:4]),
                                        hex_char(in_code[11:8]), hex_char(in_code[15:12])};
                    end
                    busy_next   = 1'b1;
                    synced_next = 1'b0;
                    pos_next    = 8'd0;
                    xor_next    = 8'd0;
                    await_next  = 1'b0;
                end
                CMD_TIMEOUT: begin
                    if (busy_reg) begin
                        do_finish  = 1'b1;
                        fin_status = ST_NO_ANSWER;
                    end
                end
                CMD_BYTE: begin
                    if (busy_reg) begin
                        if (!synced_reg) begin
                            if (in_byte == CH_STX) begin
                                synced_next = 1'b1;
                                pos_next    = 8'd1;
                                xor_next    = 8'd0;
                                await_next  = 1'b0;
                            end
                        end else if (await_reg) begin
                            do_finish  = 1'b1;
                            fin_status = (in_byte == xor_reg) ? ST_OK : ST_CHECKSUM;
                        end else if (pos_reg < hdr_len) begin
                            if (ext_mode_reg) begin
                                hdr_bad = (pos_reg == 8'd1) ? (in_byte != CH_EXT)
                                                            : (in_byte != ext_char);
                            end else begin
                                hdr_bad = (pos_reg == 8'd2)
                                    && (xor_reg != c1_reg || in_byte != c2_reg);
                            end
                            if (hdr_bad) begin
                                synced_next = 1'b0;
                                pos_next    = 8'd0;
                                xor_next    = 8'd0;
                                await_next  = 1'b0;
                            end else begin
                                xor_next = xor_reg ^ in_byte;
                                pos_next = pos_reg + 8'd1;
                            end
                        end else if (pos_reg == hdr_len && in_byte == CH_PAR) begin
                            do_finish  = 1'b1;
                            fin_status = ST_PARITY;
                        end else if (pos_reg == hdr_len && in_byte == CH_EOT) begin
                            do_finish  = 1'b1;
                            fin_status = ST_BAD_PARAM;
                        end else if (pos_reg != hdr_len && in_byte == CH_ETX) begin
                            xor_next   = xor_reg ^ in_byte;
                            await_next = 1'b1;
                        end else if (rel_pos >= 8'(MAX_DATA)) begin
                            do_finish  = 1'b1;
                            fin_status = ST_OVERFLOW;
                        end else begin
                            xor_next = xor_reg ^ in_byte;
                            pos_next = pos_reg + 8'd1;
                            do_emit  = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (do_finish) begin
            busy_next   = 1'b0;
            synced_next = 1'b0;
            await_next  = 1'b0;
        end

        m_valid_next  = m_valid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        if (do_finish) begin
            m_valid_next  = 1'b1;
            m_char_next   = 8'd0;
            m_status_next = fin_status;
            m_last_next   = 1'b1;
        end else if (do_emit) begin
            m_valid_next  = 1'b1;
            m_char_next   = in_byte;
            m_status_next = ST_OK;
            m_last_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            synced_reg   <= 1'b0;
            ext_mode_reg <= 1'b0;
            pos_reg      <= 8'd0;
            await_reg    <= 1'b0;
            xor_reg      <= 8'd0;
            exp_ext_reg  <= 48'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            synced_reg   <= synced_next;
            ext_mode_reg <= ext_mode_next;
            pos_reg      <= pos_next;
            await_reg    <= await_next;
            xor_reg      <= xor_next;
            exp_ext_reg  <= exp_ext_next;
            m_valid_reg  <= m_valid_next;
        end
        m_char_reg   <= m_char_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

endmodule

>>> hw/rtl/srd_checker.sv
module srd_checker
    import srd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic arm_word;
    logic idle_word;

    assign arm_word  = s_tvalid && s_tready && s_tuser[1:0] == CMD_ARM;
    assign idle_word = s_tvalid && s_tready && s_tuser[1:0] != CMD_ARM
        && s_tuser[1:0] != CMD_BYTE && s_tuser[1:0] != CMD_TIMEOUT;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[10:8] != 3'd6 && m_tdata[10:8] != 3'd7
            && m_tdata[7:0] == 8'd0)
        else $error("bad final status word");

    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[15:8] == 8'd0)
        else $error("value word carries status bits");

    a_arm_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        arm_word && (!m_tvalid || m_tready) |=> !m_tvalid)
        else $error("arm word produced a result");

    a_unused_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        idle_word && (!m_tvalid || m_tready) |=> !m_tvalid)
        else $error("unused command produced a result");

endmodule

bind serial_response_deframer_core srd_checker u_srd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/serial_response_deframer_core_tb.sv
`timescale 1ns / 1ps

module serial_response_deframer_core_tb;
    import srd_pkg::*;

    localparam int MAX_DATA = 128;
    localparam int PHASE_WORDS = 212;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] data_char;
        logic [2:0] status;
        logic       last;
    } answer_t;

    typedef struct {
        logic [1:0]  cmd;
        logic        ext;
        logic [15:0] code;
        logic [7:0]  sub;
        logic [7:0]  rx;
        bit          typed;
        bit          has;
        answer_t     ans;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // sideband that travels with the word being offered
    bit      word_typed = 1'b0;
    bit      word_has = 1'b0;
    answer_t word_ans = '0;

    answer_t answer_q [$];
    int      errors = 0;
    int      words_sent = 0;
    int      tx_idle_pct = 0;
    int      rx_stall_pct = 0;
    bit      hold_req = 1'b0;
    bit      hold_done = 1'b0;
    int      hold_cnt = 0;
    int      cycles = 0;

    // parser state
    logic        rx_busy = 1'b0;
    logic        rx_synced = 1'b0;
    logic        rx_ext = 1'b0;
    logic [7:0]  rx_pos = '0;
    logic        rx_await_chk = 1'b0;
    logic [7:0]  rx_xor = '0;
    logic [47:0] rx_code_chars = '0;

    dir_row_t dir_tab [24] = '{
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, CH_STX, 1'b1, 1'b0, '{8'h00, ST_OK, 1'b0}},
        '{CMD_TIMEOUT, 1'b0, 16'h0000, 8'h00, 8'h00,  1'b1, 1'b0, '{8'h00, ST_OK, 1'b0}},
        '{CMD_ARM,     1'b0, 16'hFFFF, 8'h00, 8'h00,  1'b0, 1'b0, '0},
        '{CMD_UNUSED,  1'b1, 16'hFFFF, 8'hFF, 8'hFF,  1'b1, 1'b0, '{8'h00, ST_OK, 1'b0}},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, CH_STX, 1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, 8'h7B,  1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, 8'h69,  1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, CH_PAR, 1'b1, 1'b1, '{8'h00, ST_PARITY, 1'b1}},
        '{CMD_ARM,     1'b1, 16'hFFFF, 8'hFF, 8'h00,  1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, CH_STX, 1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, CH_EXT, 1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, 8'h46,  1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, 8'h46,  1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, 8'h46,  1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, 8'h46,  1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, 8'h46,  1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, 8'h46,  1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, CH_EOT, 1'b1, 1'b1, '{8'h00, ST_BAD_PARAM, 1'b1}},
        '{CMD_ARM,     1'b0, 16'h0000, 8'h00, 8'h00,  1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, CH_STX, 1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, 8'h30,  1'b0, 1'b0, '0},
        // bad second code char that happens to be STX: must not resync on it
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, CH_STX, 1'b0, 1'b0, '0},
        '{CMD_BYTE,    1'b0, 16'h0000, 8'h00, 8'h30,  1'b0, 1'b0, '0},
        '{CMD_TIMEOUT, 1'b0, 16'h0000, 8'h00, 8'h00,  1'b1, 1'b1, '{8'h00, ST_NO_ANSWER, 1'b1}}
    };

    serial_response_deframer_core #(
        .MAX_DATA(MAX_DATA)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] v);
        return (v < 4'd10) ? 8'(48 + v) : 8'(55 + v);
    endfunction

    function automatic logic [47:0] code_chars(logic ext, logic [15:0] code, logic [7:0] sub);
        int dv;
        int md;
        if (ext)
            return {hex_char(sub[3:0]), hex_char(sub[7:4]), hex_char(code[3:0]),
                    hex_char(code[7:4]), hex_char(code[11:8]), hex_char(code[15:12])};
        dv = code / 790;
        md = code % 790;
        return {32'h0, 8'(md % 10 + dv * 10 + 48), 8'(md / 10 + 48)};
    endfunction

    task automatic parse_word(input logic [1:0] cmd, input logic ext, input logic [15:0] code,
                              input logic [7:0] sub, input logic [7:0] b,
                              output bit has, output answer_t ans);
        int  hdr;
        bit  bad;
        bit  fin;
        logic [2:0] st;
        has = 1'b0;
        ans = '0;
        fin = 1'b0;
        st = ST_OK;
        if (cmd == CMD_ARM) begin
            rx_ext = ext;
            rx_code_chars = code_chars(ext, code, sub);
            rx_busy = 1'b1;
            rx_synced = 1'b0;
            rx_pos = '0;
            rx_xor = '0;
            rx_await_chk = 1'b0;
        end else if (rx_busy && cmd == CMD_TIMEOUT) begin
            fin = 1'b1;
            st = ST_NO_ANSWER;
        end else if (rx_busy && cmd == CMD_BYTE) begin
            hdr = rx_ext ? 8 : 3;
            if (!rx_synced) begin
                if (b == CH_STX) begin
                    rx_synced = 1'b1;
                    rx_pos = 8'd1;
                    rx_xor = '0;
                    rx_await_chk = 1'b0;
                end
            end else if (rx_await_chk) begin
                fin = 1'b1;
                st = (b == rx_xor) ? ST_OK : ST_CHECKSUM;
            end else if (rx_pos < hdr) begin
                if (rx_ext)
                    bad = (rx_pos == 8'd1) ? (b != CH_EXT)
                                           : (b != rx_code_chars[8 * (rx_pos - 2) +: 8]);
                else
                    bad = (rx_pos == 8'd2) &&
                          (rx_xor != rx_code_chars[7:0] || b != rx_code_chars[15:8]);
                if (bad) begin
                    rx_synced = 1'b0;
                    rx_pos = '0;
                    rx_xor = '0;
                    rx_await_chk = 1'b0;
                end else begin
                    rx_xor ^= b;
                    rx_pos = rx_pos + 8'd1;
                end
            end else if (rx_pos == hdr && b == CH_PAR) begin
                fin = 1'b1;
                st = ST_PARITY;
            end else if (rx_pos == hdr && b == CH_EOT) begin
                fin = 1'b1;
                st = ST_BAD_PARAM;
            end else if (rx_pos != hdr && b == CH_ETX) begin
                rx_xor ^= b;
                rx_await_chk = 1'b1;
            end else if (int'(rx_pos) - hdr >= MAX_DATA) begin
                fin = 1'b1;
                st = ST_OVERFLOW;
            end else begin
                rx_xor ^= b;
                rx_pos = rx_pos + 8'd1;
                has = 1'b1;
                ans.data_char = b;
            end
        end
        if (fin) begin
            rx_busy = 1'b0;
            rx_synced = 1'b0;
            rx_await_chk = 1'b0;
            has = 1'b1;
            ans.status = st;
            ans.last = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        bit      has;
        answer_t ans;
        answer_t exp_ans;
        if (aresetn && s_tvalid && s_tready) begin
            parse_word(s_tuser[1:0], s_tuser[2], s_tdata[15:0], s_tdata[23:16],
                       s_tdata[31:24], has, ans);
            if (word_typed) begin
                has = word_has;
                ans = word_ans;
            end
            if (has)
                answer_q.push_back(ans);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, actual data_char=%h status=%0d last=%b",
                         $time, m_tdata[7:0], m_tdata[10:8], m_tlast);
            end else begin
                exp_ans = answer_q.pop_front();
                if (m_tdata[7:0] !== exp_ans.data_char) begin
                    errors++;
                    $display("%0t: data_char expected %h actual %h",
                             $time, exp_ans.data_char, m_tdata[7:0]);
                end
                if (m_tdata[10:8] !== exp_ans.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_ans.status, m_tdata[10:8]);
                end
                if (m_tlast !== exp_ans.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time, exp_ans.last, m_tlast);
                end
            end
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_cnt != 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic ext, input logic [15:0] code,
                             input logic [7:0] sub, input logic [7:0] rx,
                             input bit typed, input bit has, input answer_t ans);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {ext, cmd};
        s_tdata <= {rx, sub, code};
        word_typed <= typed;
        word_has <= has;
        word_ans <= ans;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (cmd != CMD_UNUSED)
            words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(CMD_BYTE, 1'($urandom), 16'($urandom), 8'($urandom), b, 1'b0, 1'b0, '0);
    endtask

    task automatic send_misc(input logic [1:0] cmd);
        send_word(cmd, 1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, '0);
    endtask

    task automatic gen_frame();
        logic        ext;
        logic [15:0] code;
        logic [7:0]  sub;
        logic [47:0] chars;
        logic [7:0]  b;
        logic [7:0]  x;
        int          hdr_n;
        int          bad_at;
        int          kind;
        int          n;
        ext = 1'($urandom_range(1));
        case ($urandom_range(9))
            0: code = 16'h0000;
            1: code = 16'hFFFF;
            2: code = 16'd789;
            3: code = 16'd790;
            default: code = 16'($urandom);
        endcase
        sub = 8'($urandom);
        chars = code_chars(ext, code, sub);
        send_word(CMD_ARM, ext, code, sub, 8'($urandom), 1'b0, 1'b0, '0);
        if ($urandom_range(19) == 0)
            send_misc(CMD_UNUSED);
        // line noise while hunting
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom);
                if (b == CH_STX)
                    b = 8'h55;
                send_byte(b);
            end
        end
        send_byte(CH_STX);
        hdr_n = ext ? 7 : 2;
        bad_at = ($urandom_range(11) == 0) ? $urandom_range(hdr_n - 1) : -1;
        x = '0;
        for (int k = 0; k < hdr_n; k++) begin
            if (ext)
                b = (k == 0) ? CH_EXT : chars[8 * (k - 1) +: 8];
            else
                b = chars[8 * k +: 8];
            if (k == bad_at)
                b ^= 8'($urandom_range(1, 255));
            x ^= b;
            send_byte(b);
        end
        kind = $urandom_range(99);
        if (kind < 4) begin
            send_byte(CH_PAR);
        end else if (kind < 8) begin
            send_byte(CH_EOT);
        end else if (kind < 11) begin
            send_misc(CMD_TIMEOUT);
        end else if (kind >= 14) begin
            n = (kind < 17) ? MAX_DATA + 2 : $urandom_range(12);
            for (int k = 0; k < n; k++) begin
                b = 8'($urandom);
                if (k == 0 && $urandom_range(19) == 0)
                    b = CH_ETX;
                else if (k > 0 && b == CH_ETX)
                    b = 8'h30;
                x ^= b;
                send_byte(b);
            end
            x ^= CH_ETX;
            send_byte(CH_ETX);
            if ($urandom_range(7) == 0)
                x ^= 8'($urandom_range(1, 255));
            send_byte(x);
        end
        // else: left busy, next arm drops it
        if ($urandom_range(9) == 0)
            send_byte(8'($urandom));
        if ($urandom_range(19) == 0)
            send_misc(CMD_TIMEOUT);
    endtask

    initial begin
        int base;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            send_word(dir_tab[i].cmd, dir_tab[i].ext, dir_tab[i].code, dir_tab[i].sub,
                      dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].has, dir_tab[i].ans);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  hold_req <= 1'b1; end
                1: begin tx_idle_pct = 70; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 70; end
                default: begin tx_idle_pct = 33; rx_stall_pct <= 33; end
            endcase
            base = words_sent;
            while (words_sent - base < PHASE_WORDS)
                gen_frame();
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (answer_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
